/* rtl/assert_macros.svh */
// Assertion helpers used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* rtl/hrhp_pkg.sv */
`timescale 1ns / 1ps

package hrhp_pkg;

    // Parser phases.
    typedef enum logic [3:0] {
        PH_VERSION = 4'd0,
        PH_CODE    = 4'd1,
        PH_REASON  = 4'd2,
        PH_LINE    = 4'd3,
        PH_NAME    = 4'd4,
        PH_SKIP    = 4'd5,
        PH_VALUE   = 4'd6,
        PH_BODY    = 4'd7,
        PH_DROP    = 4'd8
    } t_phase;

    // Result kinds.
    typedef enum logic [3:0] {
        K_REASON = 4'd0,
        K_NAME   = 4'd1,
        K_VALUE  = 4'd2,
        K_BODY   = 4'd3,
        K_STATUS = 4'd4,
        K_HDONE  = 4'd5,
        K_HEND   = 4'd6,
        K_ERROR  = 4'd7,
        K_OK     = 4'd8
    } t_kind;

    // Error codes.
    typedef enum logic [3:0] {
        E_NONE          = 4'd0,
        E_NO_VERSION    = 4'd1,
        E_BAD_VERSION   = 4'd2,
        E_NO_CODE       = 4'd3,
        E_NONDIGIT      = 4'd4,
        E_OPEN_STATUS   = 4'd5,
        E_TOO_MANY      = 4'd6,
        E_NO_COLON      = 4'd7,
        E_OPEN_HEADER   = 4'd8
    } t_err;

    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [3:0]  VER_LEN      = 4'd8;
    localparam logic [3:0]  VER_POS_MAX  = 4'd9;
    localparam logic [2:0]  VER_CAND_ALL = 3'b111;
    localparam logic [63:0] VER_TEXT [3] = '{"HTTP/1.0", "HTTP/1.1", "HTTP/2.0"};

    localparam logic [15:0] CODE_MAX  = 16'hffff;
    localparam logic [19:0] CODE_BASE = 20'd10;

    localparam logic [7:0] HEADER_LIMIT_RESET = 8'd32;

    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // Configuration port.
    localparam int   APB_AW           = 3;
    localparam int   APB_DW           = 32;
    localparam logic REG_HEADER_LIMIT = 1'b0;

    localparam int OUT_TDATA_W = 40;
    localparam int MAX_RES     = 3;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic [7:0] hdr_num;
        t_err       err;
    } t_result;

    // All results caused by one input byte, oldest in res[0].
    typedef struct packed {
        logic [1:0]                count;
        logic [1:0]                version;
        logic [15:0]               status;
        t_result [MAX_RES-1:0]     res;
    } t_bundle;

    function automatic logic [7:0] ver_char(input logic [1:0] idx, input logic [2:0] pos);
        return VER_TEXT[idx][{~pos, 3'b000} +: 8];
    endfunction

    // Lowest remaining candidate, zero when none is left.
    function automatic logic [1:0] ver_index(input logic [2:0] cand);
        logic [1:0] v;
        if (cand[0]) v = 2'd0;
        else if (cand[1]) v = 2'd1;
        else if (cand[2]) v = 2'd2;
        else v = 2'd0;
        return v;
    endfunction

endpackage

/* rtl/hrhp_front.sv */
`timescale 1ns / 1ps

module hrhp_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [7:0]         i_byte,
    input  logic               i_final,
    input  logic [7:0]         i_header_limit,
    output logic               o_push,
    output hrhp_pkg::t_bundle  o_bundle
);
    import hrhp_pkg::*;

    t_phase      r_phase,     n_phase;
    logic [3:0]  r_match_pos, n_match_pos;
    logic [2:0]  r_cand,      n_cand;
    logic [15:0] r_code,      n_code;
    logic [1:0]  r_flags,     n_flags;
    logic        r_held,      n_held;
    logic [7:0]  r_hdr_cnt,   n_hdr_cnt;

    // Slot 0: released CR, slot 1: byte's own result, slot 2: end of data.
    t_result     slot [MAX_RES];
    logic [2:0]  slot_v;
    t_result [MAX_RES-1:0] lst;
    logic [1:0]  cnt;
    logic        fail_b;
    t_err        fail_code;
    logic        line_en;
    t_kind       line_kind;
    logic [19:0] code_sum;
    logic [1:0]  snap_ver;
    logic [15:0] snap_code;

    always_comb begin
        n_phase     = r_phase;
        n_match_pos = r_match_pos;
        n_cand      = r_cand;
        n_code      = r_code;
        n_flags     = r_flags;
        n_held      = r_held;
        n_hdr_cnt   = r_hdr_cnt;
        slot_v      = '0;
        for (int s = 0; s < MAX_RES; s++) begin
            slot[s] = '{kind: K_BODY, data: 8'd0, hdr_num: r_hdr_cnt, err: E_NONE};
        end
        fail_b    = 1'b0;
        fail_code = E_NONE;
        line_en   = 1'b0;
        line_kind = K_VALUE;
        code_sum  = 20'(r_code) * CODE_BASE + 20'(i_byte - CH_ZERO);

        case (r_phase)
            PH_VERSION: begin
                if (i_byte == CH_SPACE) begin
                    if (r_match_pos == 4'd0) begin
                        fail_b    = 1'b1;
                        fail_code = E_NO_VERSION;
                    end else if (r_match_pos != VER_LEN || r_cand == 3'd0) begin
                        fail_b    = 1'b1;
                        fail_code = E_BAD_VERSION;
                    end else begin
                        n_phase = PH_CODE;
                        n_flags = 2'b00;
                    end
                end else begin
                    if (r_match_pos < VER_LEN) begin
                        for (int i = 0; i < 3; i++) begin
                            if (ver_char(i[1:0], r_match_pos[2:0]) != i_byte) n_cand[i] = 1'b0;
                        end
                    end else begin
                        n_cand = 3'd0;
                    end
                    if (r_match_pos < VER_POS_MAX) n_match_pos = r_match_pos + 4'd1;
                end
            end
            PH_CODE: begin
                if (i_byte == CH_SPACE) begin
                    if (!r_flags[0]) begin
                        fail_b    = 1'b1;
                        fail_code = E_NO_CODE;
                    end else if (r_flags[1]) begin
                        fail_b    = 1'b1;
                        fail_code = E_NONDIGIT;
                    end else begin
                        n_phase = PH_REASON;
                    end
                end else begin
                    n_flags[0] = 1'b1;
                    if (i_byte >= CH_ZERO && i_byte <= CH_NINE) begin
                        n_code = (code_sum > 20'(CODE_MAX)) ? CODE_MAX : code_sum[15:0];
                    end else begin
                        n_flags[1] = 1'b1;
                    end
                end
            end
            PH_REASON: begin
                line_en   = 1'b1;
                line_kind = K_REASON;
            end
            PH_LINE: begin
                if (r_held) begin
                    n_held = 1'b0;
                    if (i_byte == CH_LF) begin
                        slot_v[1]    = 1'b1;
                        slot[1].kind = K_HEND;
                        n_phase      = PH_BODY;
                    end else if (r_hdr_cnt >= i_header_limit) begin
                        fail_b    = 1'b1;
                        fail_code = E_TOO_MANY;
                    end else begin
                        // The held CR turns out to be the first name byte.
                        slot_v[0]    = 1'b1;
                        slot[0].kind = K_NAME;
                        slot[0].data = CH_CR;
                        if (i_byte == CH_COLON) begin
                            n_phase = PH_SKIP;
                        end else begin
                            slot_v[1]    = 1'b1;
                            slot[1].kind = K_NAME;
                            slot[1].data = i_byte;
                            n_phase      = PH_NAME;
                        end
                    end
                end else if (i_final) begin
                    slot_v[1]    = 1'b1;
                    slot[1].kind = K_BODY;
                    slot[1].data = i_byte;
                    n_phase      = PH_BODY;
                end else if (i_byte == CH_CR) begin
                    n_held = 1'b1;
                end else if (r_hdr_cnt >= i_header_limit) begin
                    fail_b    = 1'b1;
                    fail_code = E_TOO_MANY;
                end else if (i_byte == CH_COLON) begin
                    fail_b    = 1'b1;
                    fail_code = E_NO_COLON;
                end else begin
                    slot_v[1]    = 1'b1;
                    slot[1].kind = K_NAME;
                    slot[1].data = i_byte;
                    n_phase      = PH_NAME;
                end
            end
            PH_NAME: begin
                if (i_byte == CH_COLON) begin
                    n_phase = PH_SKIP;
                end else begin
                    slot_v[1]    = 1'b1;
                    slot[1].kind = K_NAME;
                    slot[1].data = i_byte;
                end
            end
            PH_SKIP: begin
                if (i_byte != CH_SPACE) begin
                    n_phase = PH_VALUE;
                    line_en = 1'b1;
                end
            end
            PH_VALUE: begin
                line_en = 1'b1;
            end
            PH_BODY: begin
                slot_v[1]    = 1'b1;
                slot[1].kind = K_BODY;
                slot[1].data = i_byte;
            end
            default: begin
            end
        endcase

        // Reason and value bytes share the CR hold-back.
        if (line_en) begin
            if (r_held) begin
                n_held = 1'b0;
                if (i_byte == CH_LF) begin
                    slot_v[1]    = 1'b1;
                    slot[1].kind = (line_kind == K_REASON) ? K_STATUS : K_HDONE;
                    if (line_kind != K_REASON) n_hdr_cnt = r_hdr_cnt + 8'd1;
                    n_phase = PH_LINE;
                end else begin
                    slot_v[0]    = 1'b1;
                    slot[0].kind = line_kind;
                    slot[0].data = CH_CR;
                end
            end
            if (!(r_held && i_byte == CH_LF)) begin
                if (i_byte == CH_CR) begin
                    n_held = 1'b1;
                end else begin
                    slot_v[1]    = 1'b1;
                    slot[1].kind = line_kind;
                    slot[1].data = i_byte;
                end
            end
        end

        if (fail_b) begin
            slot_v[1]    = 1'b1;
            slot[1].kind = K_ERROR;
            slot[1].err  = fail_code;
            n_phase      = PH_DROP;
            n_held       = 1'b0;
        end

        snap_ver  = ver_index(n_cand);
        snap_code = n_code;

        // End of data: the open field decides the closing result.
        if (i_final) begin
            slot[2].hdr_num = n_hdr_cnt;
            slot[2].kind    = K_ERROR;
            case (n_phase)
                PH_VERSION: begin
                    slot_v[2]   = 1'b1;
                    slot[2].err = E_NO_VERSION;
                end
                PH_CODE: begin
                    slot_v[2]   = 1'b1;
                    slot[2].err = E_NO_CODE;
                end
                PH_REASON: begin
                    slot_v[2]   = 1'b1;
                    slot[2].err = E_OPEN_STATUS;
                end
                PH_NAME: begin
                    slot_v[2]   = 1'b1;
                    slot[2].err = E_NO_COLON;
                end
                PH_SKIP, PH_VALUE: begin
                    slot_v[2]   = 1'b1;
                    slot[2].err = E_OPEN_HEADER;
                end
                PH_LINE, PH_BODY: begin
                    slot_v[2]    = 1'b1;
                    slot[2].kind = K_OK;
                end
                default: begin
                end
            endcase
            n_phase     = PH_VERSION;
            n_match_pos = 4'd0;
            n_cand      = VER_CAND_ALL;
            n_code      = 16'd0;
            n_flags     = 2'b00;
            n_held      = 1'b0;
            n_hdr_cnt   = 8'd0;
        end

        lst = '0;
        cnt = 2'd0;
        for (int s = 0; s < MAX_RES; s++) begin
            if (slot_v[s]) begin
                lst[cnt] = slot[s];
                cnt      = cnt + 2'd1;
            end
        end
    end

    assign o_push           = i_accept && (cnt != 2'd0);
    assign o_bundle.count   = cnt;
    assign o_bundle.version = snap_ver;
    assign o_bundle.status  = snap_code;
    assign o_bundle.res     = lst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_VERSION;
            r_match_pos <= 4'd0;
            r_cand      <= VER_CAND_ALL;
            r_code      <= 16'd0;
            r_flags     <= 2'b00;
            r_held      <= 1'b0;
            r_hdr_cnt   <= 8'd0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_match_pos <= n_match_pos;
            r_cand      <= n_cand;
            r_code      <= n_code;
            r_flags     <= n_flags;
            r_held      <= n_held;
            r_hdr_cnt   <= n_hdr_cnt;
        end
    end

endmodule

/* rtl/hrhp_queue.sv */
`timescale 1ns / 1ps

module hrhp_queue #(
    parameter int DEPTH = hrhp_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  hrhp_pkg::t_bundle  i_push_data,
    output logic               o_ready,
    output logic               o_valid,
    output hrhp_pkg::t_bundle  o_head,
    input  logic               i_pop
);
    import hrhp_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_bundle         r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count,  n_count;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

/* rtl/hrhp_back.sv */
`timescale 1ns / 1ps

module hrhp_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_q_valid,
    input  hrhp_pkg::t_bundle                 i_q_head,
    output logic                              o_pop,
    output logic                              o_tvalid,
    input  logic                              i_tready,
    output logic [hrhp_pkg::OUT_TDATA_W-1:0]  o_tdata,
    output logic [3:0]                        o_tuser,
    output logic                              o_tlast
);
    import hrhp_pkg::*;

    logic        r_out_valid;
    t_result     r_out;
    logic [1:0]  r_ver;
    logic [15:0] r_status;
    logic        r_last;
    logic [1:0]  r_sub;
    logic        load;
    logic        last_sel;

    // A new result enters the output register when it is empty or draining.
    assign load     = i_q_valid && (!r_out_valid || i_tready);
    assign last_sel = (r_sub == i_q_head.count - 2'd1);
    assign o_pop    = load && last_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sub       <= 2'd0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_sub       <= last_sel ? 2'd0 : r_sub + 2'd1;
            end else if (i_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out    <= i_q_head.res[r_sub];
            r_ver    <= i_q_head.version;
            r_status <= i_q_head.status;
            r_last   <= last_sel;
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tuser  = r_out.kind;
    assign o_tlast  = r_last;
    assign o_tdata  = {2'b00, r_out.err, r_out.hdr_num, r_status, r_ver, r_out.data};

endmodule

/* rtl/http_response_head_parser_core.sv */
`timescale 1ns / 1ps

// HTTP response head parser. Response bytes arrive one per transfer on the
// s_axis side, with tlast on the final byte. Each byte is classified
// combinationally into zero to three tagged results, which are queued as one
// group and sent out on the m_axis side one result per transfer, with tlast
// on the last result that a byte caused. The block takes one byte per clock
// cycle while the m_axis side is ready and bytes give at most one result each
// on average; a byte that gives two or three results needs that many output
// transfers, and the result queue (QUEUE_DEPTH groups) absorbs such bursts
// before the input stalls. A byte's first result passes the result queue and
// the output register. The header limit register lies at address 0 of the APB port.
module http_response_head_parser_core #(
    parameter int QUEUE_DEPTH = hrhp_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,  // [7:0] in_byte
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [7:0] out_byte, [9:8] version_code, [25:10] status_value,
    // [33:26] header_number, [37:34] error_code, [39:38] zero
    output logic [hrhp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic [3:0]                        m_axis_tuser,  // [3:0] kind
    output logic                              m_axis_tlast,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [hrhp_pkg::APB_AW-1:0]       paddr,
    input  logic [hrhp_pkg::APB_DW-1:0]       pwdata,
    output logic [hrhp_pkg::APB_DW-1:0]       prdata,
    output logic                              pready
);
    import hrhp_pkg::*;

    logic [7:0] r_limit;
    logic       accept;
    logic       push;
    t_bundle    push_data;
    logic       q_ready;
    logic       q_valid;
    t_bundle    q_head;
    logic       pop;
    logic       reg_sel;

    assign reg_sel = (paddr[APB_AW-1:2] == REG_HEADER_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= HEADER_LIMIT_RESET;
        end else if (psel && penable && pwrite && reg_sel) begin
            r_limit <= pwdata[7:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = reg_sel ? APB_DW'(r_limit) : '0;

    assign s_axis_tready = q_ready;
    assign accept        = s_axis_tvalid && q_ready;

    hrhp_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_byte         (s_axis_tdata),
        .i_final        (s_axis_tlast),
        .i_header_limit (r_limit),
        .o_push         (push),
        .o_bundle       (push_data)
    );

    hrhp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_ready     (q_ready),
        .o_valid     (q_valid),
        .o_head      (q_head),
        .i_pop       (pop)
    );

    hrhp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_head  (q_head),
        .o_pop     (pop),
        .o_tvalid  (m_axis_tvalid),
        .i_tready  (m_axis_tready),
        .o_tdata   (m_axis_tdata),
        .o_tuser   (m_axis_tuser),
        .o_tlast   (m_axis_tlast)
    );

endmodule

/* rtl/hrhp_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hrhp_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [hrhp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input logic [3:0]                        m_axis_tuser,
    input logic                              m_axis_tlast
);
    import hrhp_pkg::*;

    logic                   out_stall;
    logic                   out_err;
    logic                   out_ok;
    logic                   out_has_code;
    logic [OUT_TDATA_W+4:0] out_word;

    assign out_stall    = m_axis_tvalid && !m_axis_tready;
    assign out_err      = m_axis_tvalid && (m_axis_tuser == K_ERROR);
    assign out_ok       = m_axis_tvalid && (m_axis_tuser == K_OK);
    assign out_has_code = (m_axis_tdata[37:34] != E_NONE);
    assign out_word     = {m_axis_tlast, m_axis_tuser, m_axis_tdata};

    // A stalled result keeps its contents.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, m_axis_tvalid && $stable(out_word))

    // An error drops the rest of the byte's work, so it always closes the run.
    `ASSERT_IMPL(a_err_last, i_clk, i_rst_n, out_err, m_axis_tlast)

    // Message completion is the closing result of the final byte.
    `ASSERT_IMPL(a_ok_last, i_clk, i_rst_n, out_ok, m_axis_tlast)

    // An error code is carried exactly by error results.
    `ASSERT_IMPL(a_err_code, i_clk, i_rst_n, m_axis_tvalid, out_err == out_has_code)

endmodule

bind http_response_head_parser_core hrhp_checker u_hrhp_checker (.*);

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import hrhp_pkg::*;

    localparam int STALL_CYCLES = 80;
    localparam int DRAIN_SETTLE = 8;
    localparam int RANDOM_ITEMS = 100;
    localparam logic [APB_AW-1:0] ADDR_HEADER_LIMIT = '0;
    localparam string CR = "\015";
    localparam string CRLF = "\015\012";

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        logic [1:0]  version;
        logic [15:0] status;
        logic [7:0]  hdr_num;
        t_err        err;
        logic        run_end;
    } parse_result_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = 8'd0;
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [3:0]            m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_AW-1:0]     paddr = '0;
    logic [APB_DW-1:0]     pwdata = '0;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    http_response_head_parser_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    // Parser state as the block should hold it.
    t_phase      parse_phase;
    logic [3:0]  match_pos;
    logic [2:0]  version_cands;
    logic [15:0] code_acc;
    logic [1:0]  code_flags;      // [0] code not empty, [1] nondigit seen
    logic        held_cr;
    logic [7:0]  header_count;
    logic [7:0]  header_limit;

    string version_tokens [3] = '{"HTTP/1.0", "HTTP/1.1", "HTTP/2.0"};

    parse_result_t pending_parse_results [$];
    parse_result_t step_results [MAX_RES];
    int            step_count;

    int mismatch_count = 0;
    int live_bytes = 0;
    bit send_idle_en = 1'b1;
    bit sink_idle_en = 1'b1;
    int stall_requested = 0;
    int stall_served = 0;
    int stall_left = 0;
    logic [7:0] message_bytes [$];

    function automatic logic [1:0] first_candidate(input logic [2:0] cands);
        casez (cands)
            3'b??1:  return 2'd0;
            3'b?10:  return 2'd1;
            3'b100:  return 2'd2;
            default: return 2'd0;
        endcase
    endfunction

    function automatic void emit_result(input t_kind kind, input logic [7:0] data,
                                        input t_err err);
        if (step_count < MAX_RES) begin
            step_results[step_count] = '{kind: kind, data: data,
                                         version: first_candidate(version_cands),
                                         status: code_acc, hdr_num: header_count,
                                         err: err, run_end: 1'b0};
            step_count++;
        end
    endfunction

    function automatic void fail_with(input t_err err);
        emit_result(K_ERROR, 8'd0, err);
        parse_phase = PH_DROP;
        held_cr = 1'b0;
    endfunction

    function automatic void clear_parser();
        parse_phase = PH_VERSION;
        match_pos = 4'd0;
        version_cands = 3'b111;
        code_acc = 16'd0;
        code_flags = 2'b00;
        held_cr = 1'b0;
        header_count = 8'd0;
    endfunction

    function automatic void name_char(input logic [7:0] b);
        if (b == CH_COLON) parse_phase = PH_SKIP;
        else emit_result(K_NAME, b, E_NONE);
    endfunction

    // Reason and value bytes: a CR waits for the next byte to see if it ends the line.
    function automatic void line_char(input logic [7:0] b, input t_kind data_kind);
        logic line_done;
        line_done = 1'b0;
        if (held_cr) begin
            held_cr = 1'b0;
            if (b == CH_LF) begin
                if (data_kind == K_REASON) begin
                    emit_result(K_STATUS, 8'd0, E_NONE);
                end else begin
                    emit_result(K_HDONE, 8'd0, E_NONE);
                    header_count++;
                end
                parse_phase = PH_LINE;
                line_done = 1'b1;
            end else begin
                emit_result(data_kind, CH_CR, E_NONE);
            end
        end
        if (!line_done) begin
            if (b == CH_CR) held_cr = 1'b1;
            else emit_result(data_kind, b, E_NONE);
        end
    endfunction

    function automatic void parse_byte(input logic [7:0] b, input logic fin);
        int unsigned acc;
        step_count = 0;
        case (parse_phase)
            PH_VERSION: begin
                if (b == CH_SPACE) begin
                    if (match_pos == 0) begin
                        fail_with(E_NO_VERSION);
                    end else if (match_pos != 8 || version_cands == 0) begin
                        fail_with(E_BAD_VERSION);
                    end else begin
                        parse_phase = PH_CODE;
                        code_flags = 2'b00;
                    end
                end else begin
                    if (match_pos < 8) begin
                        for (int i = 0; i < 3; i++) begin
                            if (version_tokens[i][match_pos] != b) version_cands[i] = 1'b0;
                        end
                    end else begin
                        version_cands = 3'b000;
                    end
                    if (match_pos < 9) match_pos++;
                end
            end
            PH_CODE: begin
                if (b == CH_SPACE) begin
                    if (!code_flags[0]) fail_with(E_NO_CODE);
                    else if (code_flags[1]) fail_with(E_NONDIGIT);
                    else parse_phase = PH_REASON;
                end else begin
                    code_flags[0] = 1'b1;
                    if (b >= CH_ZERO && b <= CH_NINE) begin
                        acc = int'(code_acc) * 10 + int'(b) - int'(CH_ZERO);
                        code_acc = (acc > 65535) ? 16'hffff : acc[15:0];
                    end else begin
                        code_flags[1] = 1'b1;
                    end
                end
            end
            PH_REASON: line_char(b, K_REASON);
            PH_LINE: begin
                if (held_cr) begin
                    held_cr = 1'b0;
                    if (b == CH_LF) begin
                        emit_result(K_HEND, 8'd0, E_NONE);
                        parse_phase = PH_BODY;
                    end else if (header_count >= header_limit) begin
                        fail_with(E_TOO_MANY);
                    end else begin
                        emit_result(K_NAME, CH_CR, E_NONE);
                        parse_phase = PH_NAME;
                        name_char(b);
                    end
                end else if (fin) begin
                    emit_result(K_BODY, b, E_NONE);
                    parse_phase = PH_BODY;
                end else if (b == CH_CR) begin
                    held_cr = 1'b1;
                end else if (header_count >= header_limit) begin
                    fail_with(E_TOO_MANY);
                end else if (b == CH_COLON) begin
                    fail_with(E_NO_COLON);
                end else begin
                    emit_result(K_NAME, b, E_NONE);
                    parse_phase = PH_NAME;
                end
            end
            PH_NAME: name_char(b);
            PH_SKIP: begin
                if (b != CH_SPACE) begin
                    parse_phase = PH_VALUE;
                    line_char(b, K_VALUE);
                end
            end
            PH_VALUE: line_char(b, K_VALUE);
            PH_BODY:  emit_result(K_BODY, b, E_NONE);
            default: ;
        endcase

        // The field still open at the last byte decides how the response ends.
        if (fin) begin
            case (parse_phase)
                PH_VERSION:        fail_with(E_NO_VERSION);
                PH_CODE:           fail_with(E_NO_CODE);
                PH_REASON:         fail_with(E_OPEN_STATUS);
                PH_NAME:           fail_with(E_NO_COLON);
                PH_SKIP, PH_VALUE: fail_with(E_OPEN_HEADER);
                PH_LINE, PH_BODY:  emit_result(K_OK, 8'd0, E_NONE);
                default: ;
            endcase
            clear_parser();
        end

        for (int i = 0; i < step_count; i++) begin
            step_results[i].run_end = (i == step_count - 1);
            pending_parse_results.push_back(step_results[i]);
        end
    endfunction

    function automatic void report_mismatch(input string what, input parse_result_t want,
                                            input parse_result_t got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%s: expected kind %0d byte %02h ver %0d status %0d hdr %0d err %0d last %0b",
                     what, want.kind, want.data, want.version, want.status, want.hdr_num,
                     want.err, want.run_end);
            $display("    got kind %0d byte %02h ver %0d status %0d hdr %0d err %0d last %0b",
                     got.kind, got.data, got.version, got.status, got.hdr_num, got.err,
                     got.run_end);
        end
    endfunction

    always @(posedge i_clk) begin : response_check
        parse_result_t got;
        parse_result_t want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                if (parse_phase != PH_DROP) live_bytes++;
                parse_byte(s_axis_tdata, s_axis_tlast);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.kind    = t_kind'(m_axis_tuser);
                got.data    = m_axis_tdata[7:0];
                got.version = m_axis_tdata[9:8];
                got.status  = m_axis_tdata[25:10];
                got.hdr_num = m_axis_tdata[33:26];
                got.err     = t_err'(m_axis_tdata[37:34]);
                got.run_end = m_axis_tlast;
                if (pending_parse_results.size() == 0) begin
                    report_mismatch("unexpected result", '0, got);
                end else begin
                    want = pending_parse_results.pop_front();
                    if (got !== want) report_mismatch("wrong result", want, got);
                end
            end
        end
    end

    // Result side: random idling, or a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (stall_requested != stall_served) begin
            stall_served = stall_served + 1;
            stall_left = STALL_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !sink_idle_en || ($urandom_range(99) >= 38);
        end
    end

    task automatic send_byte(input logic [7:0] value, input logic last);
        while (send_idle_en && $urandom_range(99) < 38) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic send_text(input string text, input logic last_at_end);
        for (int i = 0; i < text.len(); i++) begin
            send_byte(text[i], last_at_end && (i == text.len() - 1));
        end
    endtask

    // The first edge lets the check process take in the last transfer.
    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_parse_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_SETTLE) @(posedge i_clk);
    endtask

    // Write the header limit with the parser idle, then read it back.
    task automatic write_header_limit(input logic [7:0] value);
        wait_drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_HEADER_LIMIT;
        pwdata  <= APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        header_limit = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== APB_DW'(value)) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("header limit read back %0h, expected %0h", prdata, value);
            end
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic void append_text(input string text);
        for (int i = 0; i < text.len(); i++) message_bytes.push_back(text[i]);
    endfunction

    function automatic logic [7:0] random_text_char();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70) return 8'($urandom_range(8'h7a, 8'h61));
        else if (roll < 80) return CH_SPACE;
        else if (roll < 86) return CH_CR;
        else if (roll < 90) return CH_COLON;
        else return 8'($urandom_range(255));
    endfunction

    // Mostly well-formed responses with random content, some broken or cut short,
    // and now and then plain noise.
    task automatic send_random_message();
        int roll;
        int len;
        message_bytes.delete();
        if ($urandom_range(99) < 8) begin
            len = $urandom_range(6, 1);
            repeat (len) message_bytes.push_back(8'($urandom_range(255)));
        end else begin
            roll = $urandom_range(99);
            if (roll < 85) begin
                append_text(version_tokens[$urandom_range(2)]);
            end else if (roll < 92) begin
                append_text(version_tokens[$urandom_range(2)]);
                message_bytes[$urandom_range(7)] = 8'($urandom_range(255));
            end else if (roll < 96) begin
                append_text({version_tokens[$urandom_range(2)], "1"});
            end
            message_bytes.push_back(CH_SPACE);
            roll = $urandom_range(99);
            if (roll < 94) begin
                len = (roll < 82) ? $urandom_range(3, 1) : $urandom_range(6, 5);
                repeat (len) message_bytes.push_back(8'(CH_ZERO + $urandom_range(9)));
                // Spoil one of the code digits just pushed.
                if (roll >= 88) begin
                    message_bytes[message_bytes.size() - 1 - $urandom_range(len - 1)] =
                        random_text_char();
                end
            end
            message_bytes.push_back(CH_SPACE);
            len = $urandom_range(4);
            repeat (len) message_bytes.push_back(random_text_char());
            append_text(CRLF);
            repeat ($urandom_range(3)) begin
                if ($urandom_range(99) < 6) message_bytes.push_back(CH_COLON);
                len = $urandom_range(3, 1);
                repeat (len) begin
                    if ($urandom_range(99) < 10) message_bytes.push_back(CH_CR);
                    else message_bytes.push_back(8'($urandom_range(8'h5a, 8'h41)));
                end
                message_bytes.push_back(CH_COLON);
                repeat ($urandom_range(2)) message_bytes.push_back(CH_SPACE);
                len = $urandom_range(3);
                repeat (len) message_bytes.push_back(random_text_char());
                append_text(CRLF);
            end
            append_text(CRLF);
            repeat ($urandom_range(4)) message_bytes.push_back(8'($urandom_range(255)));
        end
        if ($urandom_range(99) < 20) begin
            len = $urandom_range(message_bytes.size(), 1);
            while (message_bytes.size() > len) void'(message_bytes.pop_back());
        end
        for (int i = 0; i < message_bytes.size(); i++) begin
            send_byte(message_bytes[i], i == message_bytes.size() - 1);
        end
    endtask

    task automatic test_basic_responses();
        send_idle_en = 1'b0;
        sink_idle_en = 1'b0;
        send_text({"HTTP/1.1 200 OK", CRLF, "Host: a", CRLF, CRLF, "hi"}, 1'b1);
        send_text({"HTTP/1.0 404 ", CRLF, CRLF}, 1'b1);
        // Status code saturates; a single last byte at a line start is body.
        send_text({"HTTP/2.0 99999 X", CRLF, "Q"}, 1'b1);
        send_idle_en = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    task automatic test_version_errors();
        send_text(" ", 1'b1);
        send_text("HTTP/1.2 200", 1'b1);
        send_text("HTTP/1.00 x", 1'b1);
        send_text("HTTP/1", 1'b1);
    endtask

    task automatic test_status_code_errors();
        send_text("HTTP/1.1  x", 1'b1);
        send_text("HTTP/1.1 2a0 x", 1'b1);
        send_text("HTTP/1.1 20", 1'b1);
    endtask

    task automatic test_line_rules();
        // Lone CRs in reason, name and value; leading value spaces; a line
        // starting with a CR that is not a CRLF; body bytes at both extremes.
        send_text({"HTTP/1.1 200 A", CR, "B", CRLF, "N", CR, "m:   v", CR, "w", CRLF,
                   CR, "x: y", CRLF, CRLF}, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b1);
        send_text({"HTTP/1.1 200 OK", CRLF, ":v", CRLF}, 1'b1);
        send_text({"HTTP/1.1 200 OK", CRLF, "Nm"}, 1'b1);
        send_text({"HTTP/1.1 200 OK", CRLF, "N: v"}, 1'b1);
        send_text({"HTTP/1.1 200 OK", CRLF, "N:"}, 1'b1);
        send_text({"HTTP/1.1 200 OK", CR}, 1'b1);
        send_text({"HTTP/1.1 200 OK", CRLF, "N: v", CRLF}, 1'b1);
    endtask

    task automatic test_header_limit();
        write_header_limit(8'd0);
        send_text({"HTTP/1.1 200 OK", CRLF, "A: b", CRLF, CRLF}, 1'b1);
        send_text({"HTTP/1.1 200 OK", CRLF, CR, "x", CRLF, CRLF}, 1'b1);
        send_text({"HTTP/1.1 200 OK", CRLF, CRLF, "z"}, 1'b1);
        write_header_limit(8'd1);
        send_text({"HTTP/1.1 200 OK", CRLF, "A: b", CRLF, "C: d", CRLF, CRLF}, 1'b1);
        write_header_limit(8'd255);
        send_text({"HTTP/1.1 200 OK", CRLF, "A: b", CRLF, "C: d", CRLF, "E:f", CRLF, CRLF},
                  1'b1);
        write_header_limit(HEADER_LIMIT_RESET);
    endtask

    task automatic test_backpressure();
        send_idle_en = 1'b0;
        send_text({"HTTP/1.1 200 OK", CRLF, CRLF}, 1'b0);
        // The result side holds off while bytes keep coming, so the block fills up.
        stall_requested++;
        repeat (40) send_byte(8'($urandom_range(255)), 1'b0);
        send_byte(8'h5a, 1'b1);
        send_idle_en = 1'b1;
        wait_drain();
        send_text({"HTTP/1.0 204 A", CR, "B", CR}, 1'b0);
        send_byte(8'h41, 1'b1);
    endtask

    task automatic test_random_messages();
        int start_count;
        int msg_index;
        int roll;
        start_count = live_bytes;
        msg_index = 0;
        while (live_bytes - start_count < RANDOM_ITEMS) begin
            send_idle_en = (msg_index >= 4);
            sink_idle_en = (msg_index >= 4);
            if (msg_index > 0 && $urandom_range(99) < 15) begin
                roll = $urandom_range(99);
                if (roll < 20) write_header_limit(8'd0);
                else if (roll < 50) write_header_limit(8'($urandom_range(3, 1)));
                else if (roll < 65) write_header_limit(8'd255);
                else write_header_limit(8'($urandom_range(255)));
            end
            send_random_message();
            msg_index++;
        end
    endtask

    initial begin
        clear_parser();
        header_limit = HEADER_LIMIT_RESET;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_basic_responses();
        test_version_errors();
        test_status_code_errors();
        test_line_rules();
        test_header_limit();
        test_backpressure();
        test_random_messages();
        wait_drain();
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d results outstanding", pending_parse_results.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

/* http_response_head_parser_core.f */
+incdir+rtl
rtl/hrhp_pkg.sv
rtl/hrhp_front.sv
rtl/hrhp_queue.sv
rtl/hrhp_back.sv
rtl/http_response_head_parser_core.sv
rtl/hrhp_checker.sv
test/testbench.sv
